[rtl/bbc_pkg.sv]
// types and constants shared by the bracket balance checker
package bbc_pkg;

  // opening and closing characters
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_RPAREN   = 8'h29;

  typedef enum logic [1:0] {
    KIND_BRACE   = 2'd0,
    KIND_BRACKET = 2'd1,
    KIND_PAREN   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_EMPTY_CLOSE = 3'd2,
    ST_UNCLOSED    = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] status;
  } out_beat_t;

  // decoded character
  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } decode_t;

  // shift control for the cell row
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

[rtl/bbc_decode.sv]
// character decoder: opener / closer and bracket kind
module bbc_decode import bbc_pkg::*; (
  input  logic [7:0] symbol_i,
  output decode_t    dec_o
);

  always_comb begin
    dec_o = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_NONE};
    case (symbol_i)
      CH_LBRACE: begin
        dec_o = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
      end
      CH_LBRACKET: begin
        dec_o = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACKET};
      end
      CH_LPAREN: begin
        dec_o = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      end
      CH_RBRACE: begin
        dec_o = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
      end
      CH_RBRACKET: begin
        dec_o = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACKET};
      end
      CH_RPAREN: begin
        dec_o = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      end
      default: begin
        dec_o = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_NONE};
      end
    endcase
  end

endmodule

[rtl/bbc_cell.sv]
// one stack cell: holds a kind, shifts down on push and up on pop
module bbc_cell import bbc_pkg::*; (
  input  logic        clk_i,
  input  shift_ctrl_t ctrl_i,
  input  kind_e       above_i,
  input  kind_e       below_i,
  output kind_e       kind_o
);

  kind_e kind_q, kind_d;

  always_comb begin
    kind_d = kind_q;
    if (ctrl_i.push) begin
      kind_d = above_i;
    end else if (ctrl_i.pop) begin
      kind_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

[rtl/bracket_balance_checker_core.sv]
// top level of the bracket balance checker: cell-row stack, control, output skid
//
// usage
//   in channel:  one beat per expression character (symbol, last flag)
//   out channel: one beat per expression, sent for the beat flagged last,
//                carrying balanced and status (ok, mismatch, close on empty,
//                unclosed, overflow); status is the first error seen
//   throughput:  one input beat per cycle while in_ready_o is high; the stack is
//                a row of STACK_DEPTH cells that all shift in the same cycle, so
//                the cost of a push or pop does not depend on the depth
//   output:      the result is registered into the output register when the last
//                beat is accepted, or into the skid entry while the output is held
//   stalls:      the result sits in an output register backed by one skid
//                entry; input beats keep flowing while a result waits, and
//                in_ready_o drops only when both entries hold results
//   reset:       clears the fill count, the held error and the output
//                valids; the cell contents need no reset since only cells
//                below the fill count are ever read
//   after each result the fill count and error return to zero for the
//   next expression
module bracket_balance_checker_core import bbc_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  // control state
  logic [CW-1:0] count_q, count_d;
  status_e       err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  out_beat_t     out_q, out_d;
  out_beat_t     skid_q, skid_d;

  logic        in_fire, out_fire;
  decode_t     dec;
  shift_ctrl_t ctrl;
  kind_e       cell_kind [STACK_DEPTH];
  logic        empty, full, err_held;
  status_e     err_next, status;
  logic [CW-1:0] count_next;
  out_beat_t   result;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  bbc_decode u_decode (
    .symbol_i (in_data_i.symbol),
    .dec_o    (dec)
  );

  assign empty    = (count_q == '0);
  assign full     = (count_q == FULL_COUNT);
  assign err_held = (err_q != ST_OK);

  // once an error is held the stack is frozen until the last beat
  assign ctrl.push = in_fire && !err_held && dec.is_open && !full;
  assign ctrl.pop  = in_fire && !err_held && dec.is_close && !empty;

  // row of cells, cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_e above, below;
    if (i == 0) begin : g_top
      assign above = dec.kind;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_kind[i];
    end else begin : g_upper
      assign below = cell_kind[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .kind_o  (cell_kind[i])
    );
  end

  // error and fill count after this beat
  always_comb begin
    err_next   = err_q;
    count_next = count_q;
    if (in_fire && !err_held) begin
      if (dec.is_open) begin
        if (full) begin
          err_next = ST_OVERFLOW;
        end else begin
          count_next = count_q + 1'b1;
        end
      end else if (dec.is_close) begin
        if (empty) begin
          err_next = ST_EMPTY_CLOSE;
        end else begin
          count_next = count_q - 1'b1;
          // top entry must match the closer
          if (cell_kind[0] != dec.kind) begin
            err_next = ST_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    status = err_next;
    if (err_next == ST_OK && count_next != '0) begin
      status = ST_UNCLOSED;
    end
    result.balanced = (status == ST_OK);
    result.status   = status;
  end

  always_comb begin
    count_d = count_next;
    err_d   = err_next;
    // last beat closes the expression
    if (in_fire && in_data_i.last) begin
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  // output register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire && in_data_i.last) begin
      if (!out_valid_q || out_fire) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      err_q        <= ST_OK;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("stack fill count exceeds depth");

  // skid entry only holds a result behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid valid without output valid");

  // last beat leaves a clean stack and no held error
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last) |=> (count_q == '0 && err_q == ST_OK))
    else $error("state not cleared after last beat");

  // push and pop never in the same cycle, never pop when empty
  a_shift_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.push && ctrl.pop) && !(ctrl.pop && empty))
    else $error("illegal stack shift");

endmodule
